@@ sv/bbled_pkg.sv @@
// ----------------------------------------------------------------------------
// bbled_pkg: shared types and constants for the bouncing ball LED effect
// Holds the sequencer state type, register indexes, request codes and the
// fixed-point constants of the ball physics.
// ----------------------------------------------------------------------------
package bbled_pkg;

  // Default sizes for the top-level parameters
  localparam int MAX_BALLS_DEF    = 8;
  localparam int STRIP_LENGTH_DEF = 60;

  // Port widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int COUNT_W    = 4;
  localparam int COLOR_W    = 8;
  localparam int PIX_W      = 6;
  localparam int TIME_W     = 32;

  // Fixed-point widths
  localparam int MS_W    = 16;   // saturated elapsed milliseconds
  localparam int Y_W     = 29;   // ms * 8192 + 62
  localparam int TQ_W    = 23;   // elapsed seconds, Q.16
  localparam int SQ_W    = 29;   // t^2, Q.16
  localparam int LIN_W   = 27;   // v * t, Q.16
  localparam int GRAV_W  = 31;   // 4.905 * t^2, Q.16
  localparam int SPD_W   = 20;   // speed, Q4.16
  localparam int DAMP_W  = 16;   // damping, Q0.16
  localparam int NN_W    = 8;    // square of the ball count
  localparam int DIV_W   = 20;   // damping dividend
  localparam int MUL_W   = 32;   // shared multiplier operand width
  localparam int PROD_W  = 64;

  // Physics constants
  localparam logic [SPD_W-1:0]  START_SPEED = SPD_W'(290288);
  localparam logic [MUL_W-1:0]  HALF_G      = MUL_W'(321454);
  localparam logic [SPD_W-1:0]  SPEED_MIN   = SPD_W'(656);
  localparam logic [DAMP_W-1:0] DAMP_BASE   = DAMP_W'(58982);
  localparam logic [MS_W-1:0]   ELAPSED_MAX = {MS_W{1'b1}};

  // ms to Q.16 seconds: floor((ms*8192 + 62) / 125) via reciprocal
  localparam logic [Y_W-1:0]   MS_ROUND    = Y_W'(62);
  localparam logic [MUL_W-1:0] RECIP_125   = MUL_W'(549755813);
  localparam int               RECIP_SHIFT = 36;
  localparam int               DIVISOR_125 = 125;

  // Ball count after reset
  localparam int RESET_BALLS = 3;
  localparam int RESET_NN    = RESET_BALLS * RESET_BALLS;

  // Request codes
  localparam logic REQ_RESTART = 1'b0;
  localparam logic REQ_FRAME   = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BALL_COUNT  = 2'd0,
    REG_COLOR_RED   = 2'd1,
    REG_COLOR_GREEN = 2'd2,
    REG_COLOR_BLUE  = 2'd3
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RS_SQUARE,
    ST_RS_INIT,
    ST_RS_DIV,
    ST_RS_WRITE,
    ST_FR_LOAD,
    ST_FR_RECIP,
    ST_FR_CORR,
    ST_FR_SQ,
    ST_FR_LIN,
    ST_FR_GRAV,
    ST_FR_CMP,
    ST_FR_DAMP,
    ST_FR_EMIT
  } state_t;

  // Damping of ball i after reset: 0.90 - i/9, clamped at zero
  function automatic logic [DAMP_W-1:0] damp_reset(input int i);
    int d;
    d = int'(DAMP_BASE) - ((i * 65536 + RESET_NN / 2) / RESET_NN);
    if (d < 0) begin
      d = 0;
    end
    return DAMP_W'(d);
  endfunction

endpackage

@@ sv/bouncing_ball_led_effect.sv @@
// ----------------------------------------------------------------------------
// bouncing_ball_led_effect: bouncing balls effect for an LED strip
// Keeps per-ball bounce time, speed and damping, and on each frame
// transaction emits one lit pixel per ball from a fixed-point height model.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A restart squares the ball count, then
// takes each ball's damping from a one-bit-per-cycle restoring divider (20
// steps plus setup and write-back). A frame steps each ball through load,
// recip, corr, sq, lin, grav, cmp, damp and emit, waiting in emit while the
// result channel stalls; all of these but load, corr and emit feed the single
// shared 32x32 multiplier. in_stall is high from the accepting edge until a
// restart has written its last ball or a frame's last result is loaded into
// the output register, which then holds it while the next transaction is taken.
module bouncing_ball_led_effect #(
  parameter int MAX_BALLS    = bbled_pkg::MAX_BALLS_DEF,
  parameter int STRIP_LENGTH = bbled_pkg::STRIP_LENGTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration port
  input  logic                             cfg_wr_en,
  input  logic [bbled_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbled_pkg::CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_req_type,
  input  logic [bbled_pkg::TIME_W-1:0]     in_now_ms,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bbled_pkg::PIX_W-1:0]      out_pixel_index,
  output logic [bbled_pkg::COLOR_W-1:0]    out_pixel_red,
  output logic [bbled_pkg::COLOR_W-1:0]    out_pixel_green,
  output logic [bbled_pkg::COLOR_W-1:0]    out_pixel_blue,
  output logic                             out_last_of_frame
);
  import bbled_pkg::*;

  localparam int BIDX_W = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1;
  localparam int CNT_W  = $clog2(MAX_BALLS + 1);
  localparam int POS_W  = $clog2(STRIP_LENGTH);
  localparam int DCNT_W = $clog2(DIV_W);
  localparam int RESET_ACTIVE = (RESET_BALLS > MAX_BALLS) ? MAX_BALLS : RESET_BALLS;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(STRIP_LENGTH - 1);

  // Round a Q.32 product back to Q.16
  function automatic logic [PROD_W-17:0] rnd16(input logic [PROD_W-1:0] p);
    logic [PROD_W-1:0] s;
    s = p + PROD_W'(32768);
    return s[PROD_W-1:16];
  endfunction

  // Registers
  state_t               state_r, state_nxt;
  logic [COUNT_W-1:0]   ball_count_r;
  logic [COLOR_W-1:0]   color_red_r, color_green_r, color_blue_r;
  logic [CNT_W-1:0]     active_r;
  logic [CNT_W-1:0]     ball_idx_r;
  logic [TIME_W-1:0]    now_r;
  logic [PROD_W-1:0]    prod_r;
  logic [Y_W-1:0]       y_r;
  logic [TQ_W-1:0]      tq_r;
  logic [SQ_W-1:0]      sq_r;
  logic [LIN_W-1:0]     lin_r;
  logic [LIN_W-1:0]     h_r;
  logic                 bounce_r;
  logic [NN_W-1:0]      nn_r;
  logic [NN_W-1:0]      div_rem_r;
  logic [DIV_W-1:0]     div_num_r;
  logic [DCNT_W-1:0]    div_cnt_r;
  logic                 out_valid_r;
  logic [PIX_W-1:0]     out_index_r;
  logic [COLOR_W-1:0]   out_red_r, out_green_r, out_blue_r;
  logic                 out_last_r;

  // Per-ball state
  logic [TIME_W-1:0]    bt_r   [MAX_BALLS];
  logic [SPD_W-1:0]     spd_r  [MAX_BALLS];
  logic [DAMP_W-1:0]    damp_r [MAX_BALLS];

  // Combinational signals
  logic                 in_acc;
  logic                 out_free;
  logic                 last_ball;
  logic                 mul_en;
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [CNT_W-1:0]     n_clamp;
  logic [BIDX_W-1:0]    bidx;
  logic [TIME_W-1:0]    ms_diff;
  logic [MS_W-1:0]      ms_sat;
  logic [TQ_W-1:0]      q_est;
  logic [MUL_W-1:0]     q_x125;
  logic [MUL_W-1:0]     q_rem;
  logic [TQ_W-1:0]      tq_fix;
  logic [GRAV_W-1:0]    grav;
  logic [SPD_W-1:0]     spd_damped;
  logic [PROD_W-17:0]   pos_full;
  logic [POS_W-1:0]     pos_cap;
  logic [NN_W:0]        div_trial;
  logic                 div_bit;
  logic [DIV_W:0]       damp_diff;
  logic [DAMP_W-1:0]    damp_new;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign bidx     = ball_idx_r[BIDX_W-1:0];
  assign last_ball = ((ball_idx_r + CNT_W'(1)) == active_r);

  // Clamp the ball count register into 1..MAX_BALLS
  always_comb begin
    if (ball_count_r == '0) begin
      n_clamp = CNT_W'(1);
    end else if (32'(ball_count_r) > 32'(MAX_BALLS)) begin
      n_clamp = CNT_W'(MAX_BALLS);
    end else begin
      n_clamp = CNT_W'(ball_count_r);
    end
  end

  // Elapsed time since the last bounce, saturated
  always_comb begin
    ms_diff = now_r - bt_r[bidx];
    ms_sat  = (|ms_diff[TIME_W-1:MS_W]) ? ELAPSED_MAX : ms_diff[MS_W-1:0];
  end

  // Correct the reciprocal estimate of y / 125 by one step
  always_comb begin
    q_est  = prod_r[RECIP_SHIFT+TQ_W-1:RECIP_SHIFT];
    q_x125 = MUL_W'(q_est) * MUL_W'(DIVISOR_125);
    q_rem  = MUL_W'(y_r) - q_x125;
    tq_fix = (q_rem >= MUL_W'(DIVISOR_125)) ? q_est + TQ_W'(1) : q_est;
  end

  // Gravity term, damped speed and pixel position from the product
  always_comb begin
    grav       = GRAV_W'(rnd16(prod_r));
    spd_damped = SPD_W'(rnd16(prod_r));
    pos_full   = rnd16(prod_r);
    pos_cap    = (pos_full > (PROD_W-16)'(POS_MAX)) ? POS_MAX : pos_full[POS_W-1:0];
  end

  // One restoring division step and the damping that follows
  always_comb begin
    div_trial = {div_rem_r, div_num_r[DIV_W-1]};
    div_bit   = (div_trial >= {1'b0, nn_r});
    damp_diff = {1'b0, DIV_W'(DAMP_BASE)} - {1'b0, div_num_r};
    damp_new  = damp_diff[DIV_W] ? '0 : damp_diff[DAMP_W-1:0];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_req_type == REQ_RESTART) ? ST_RS_SQUARE : ST_FR_LOAD;
        end
      end
      ST_RS_SQUARE: state_nxt = ST_RS_INIT;
      ST_RS_INIT:   state_nxt = ST_RS_DIV;
      ST_RS_DIV: begin
        if (div_cnt_r == DCNT_W'(DIV_W - 1)) begin
          state_nxt = ST_RS_WRITE;
        end
      end
      ST_RS_WRITE:  state_nxt = last_ball ? ST_IDLE : ST_RS_INIT;
      ST_FR_LOAD:   state_nxt = ST_FR_RECIP;
      ST_FR_RECIP:  state_nxt = ST_FR_CORR;
      ST_FR_CORR:   state_nxt = ST_FR_SQ;
      ST_FR_SQ:     state_nxt = ST_FR_LIN;
      ST_FR_LIN:    state_nxt = ST_FR_GRAV;
      ST_FR_GRAV:   state_nxt = ST_FR_CMP;
      ST_FR_CMP:    state_nxt = ST_FR_DAMP;
      ST_FR_DAMP:   state_nxt = ST_FR_EMIT;
      ST_FR_EMIT: begin
        if (out_free) begin
          state_nxt = last_ball ? ST_IDLE : ST_FR_LOAD;
        end
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and shared multiplier operands
  always_comb begin
    in_stall = 1'b1;
    mul_en   = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_RS_SQUARE: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(active_r);
        mul_b  = MUL_W'(active_r);
      end
      ST_FR_RECIP: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(y_r);
        mul_b  = RECIP_125;
      end
      ST_FR_SQ: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(tq_r);
        mul_b  = MUL_W'(tq_r);
      end
      ST_FR_LIN: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(spd_r[bidx]);
        mul_b  = MUL_W'(tq_r);
      end
      ST_FR_GRAV: begin
        mul_en = 1'b1;
        mul_a  = HALF_G;
        mul_b  = MUL_W'(sq_r);
      end
      ST_FR_CMP: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(spd_r[bidx]);
        mul_b  = MUL_W'(damp_r[bidx]);
      end
      ST_FR_DAMP: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(h_r);
        mul_b  = MUL_W'(STRIP_LENGTH - 1);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      active_r   <= CNT_W'(RESET_ACTIVE);
      ball_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        ball_idx_r <= '0;
        if (in_req_type == REQ_RESTART) begin
          active_r <= n_clamp;
        end
      end else if ((state_r == ST_RS_WRITE) ||
                   ((state_r == ST_FR_EMIT) && out_free)) begin
        ball_idx_r <= ball_idx_r + CNT_W'(1);
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ball_count_r  <= COUNT_W'(RESET_BALLS);
      color_red_r   <= COLOR_W'(255);
      color_green_r <= '0;
      color_blue_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BALL_COUNT:  ball_count_r  <= cfg_data[COUNT_W-1:0];
        REG_COLOR_RED:   color_red_r   <= cfg_data[COLOR_W-1:0];
        REG_COLOR_GREEN: color_green_r <= cfg_data[COLOR_W-1:0];
        REG_COLOR_BLUE:  color_blue_r  <= cfg_data[COLOR_W-1:0];
        default:         ball_count_r  <= ball_count_r;
      endcase
    end
  end

  // Shared multiplier, product held between uses
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_r <= in_now_ms;
    end
    unique case (state_r)
      ST_RS_INIT: begin
        nn_r      <= prod_r[NN_W-1:0];
        div_rem_r <= '0;
        div_cnt_r <= '0;
        div_num_r <= (DIV_W'(ball_idx_r) << 16) + DIV_W'(prod_r[NN_W-1:1]);
      end
      ST_RS_DIV: begin
        div_rem_r <= div_bit ? NN_W'(div_trial - {1'b0, nn_r}) : div_trial[NN_W-1:0];
        div_num_r <= {div_num_r[DIV_W-2:0], div_bit};
        div_cnt_r <= div_cnt_r + DCNT_W'(1);
      end
      ST_FR_LOAD: y_r  <= {ms_sat, 13'd0} + MS_ROUND;
      ST_FR_CORR: tq_r <= tq_fix;
      ST_FR_LIN:  sq_r <= SQ_W'(rnd16(prod_r));
      ST_FR_GRAV: lin_r <= LIN_W'(rnd16(prod_r));
      ST_FR_CMP: begin
        bounce_r <= (32'(lin_r) < 32'(grav));
        h_r      <= (32'(lin_r) < 32'(grav)) ? '0 : LIN_W'(32'(lin_r) - 32'(grav));
      end
      default: begin
        bounce_r <= bounce_r;
      end
    endcase
  end

  // Per-ball state: restart fills a ball, a bounce rewrites it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_BALLS; i++) begin
        bt_r[i]   <= '0;
        spd_r[i]  <= START_SPEED;
        damp_r[i] <= damp_reset(i);
      end
    end else if (state_r == ST_RS_WRITE) begin
      bt_r[bidx]   <= now_r;
      spd_r[bidx]  <= START_SPEED;
      damp_r[bidx] <= damp_new;
    end else if ((state_r == ST_FR_DAMP) && bounce_r) begin
      bt_r[bidx]  <= now_r;
      spd_r[bidx] <= (spd_damped < SPEED_MIN) ? START_SPEED : spd_damped;
    end
  end

  // Output register: load a pixel, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_FR_EMIT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_FR_EMIT) && out_free) begin
      out_index_r <= PIX_W'(pos_cap);
      out_red_r   <= color_red_r;
      out_green_r <= color_green_r;
      out_blue_r  <= color_blue_r;
      out_last_r  <= last_ball;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_index   = out_index_r;
  assign out_pixel_red     = out_red_r;
  assign out_pixel_green   = out_green_r;
  assign out_pixel_blue    = out_blue_r;
  assign out_last_of_frame = out_last_r;

endmodule

@@ dv/tb_bouncing_ball_led_effect.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bouncing_ball_led_effect: self-checking bench for the bouncing ball effect
// Drives restart and frame transactions with a wrapping millisecond clock,
// predicts every ball pixel with a fixed-point model of the ball physics and
// compares each result field by field. Both channels idle at random; one
// phase runs without idling and one holds the result channel off for a long
// stretch so the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_bouncing_ball_led_effect;
  import bbled_pkg::*;

  localparam int NUM_BALLS = MAX_BALLS_DEF;
  localparam int STRIP_LEN = STRIP_LENGTH_DEF;

  // Ball physics in fixed point
  localparam logic [19:0] SPEED_START  = 20'd290288;  // sqrt(19.62), Q4.16
  localparam logic [19:0] SPEED_FLOOR  = 20'd656;     // 0.01, Q4.16
  localparam logic [63:0] HALF_GRAVITY = 64'd321454;  // 4.905, Q.16
  localparam logic [63:0] DAMP_TOP     = 64'd58982;   // 0.90, Q0.16
  localparam logic [31:0] ELAPSED_CAP  = 32'd65535;

  // Run control
  localparam int RESTART_SETTLE = 1 + 23 * NUM_BALLS + 40;
  localparam int HOLD_CYCLES    = 600;
  localparam int RANDOM_ITEMS   = 340;
  localparam int CYCLE_LIMIT    = 600000;

  typedef struct packed {
    logic [PIX_W-1:0]   pos;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last;
  } pixel_t;

  // Predicted ball state and the pixels still owed by the block
  class pixel_scoreboard;
    pixel_t      owed_pixels[$];
    logic [31:0] bounce_ms[NUM_BALLS];
    logic [19:0] speed[NUM_BALLS];
    logic [15:0] damping[NUM_BALLS];
    int unsigned live_balls;
    logic [3:0]  ball_count;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    int unsigned errors;

    function new();
      ball_count = 4'd3;
      red        = 8'hFF;
      green      = 8'h00;
      blue       = 8'h00;
      errors     = 0;
      live_balls = balls_for(4'd3);
      for (int unsigned i = 0; i < NUM_BALLS; i++) begin
        bounce_ms[i] = 32'd0;
        speed[i]     = SPEED_START;
        damping[i]   = damping_of(i, 3);
      end
    endfunction

    // 0.90 - i/n^2, clamped at zero
    function logic [15:0] damping_of(int unsigned i, int unsigned n);
      logic [63:0] nn;
      logic [63:0] quot;
      nn   = 64'(n) * 64'(n);
      quot = (64'(i) * 64'd65536 + nn / 2) / nn;
      if (quot > DAMP_TOP) begin
        return 16'd0;
      end
      return 16'(DAMP_TOP - quot);
    endfunction

    function int unsigned balls_for(logic [3:0] n);
      if (n == 4'd0) begin
        return 1;
      end
      if (n > NUM_BALLS) begin
        return NUM_BALLS;
      end
      return n;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [7:0] data);
      case (idx)
        REG_BALL_COUNT:  ball_count = data[3:0];
        REG_COLOR_RED:   red = data;
        REG_COLOR_GREEN: green = data;
        REG_COLOR_BLUE:  blue = data;
        default: ;
      endcase
    endfunction

    // Advance the ball state for one accepted transaction
    function void note_request(logic req, logic [31:0] now);
      logic [31:0]        ms;
      logic [63:0]        tq;
      logic [63:0]        sq;
      logic [63:0]        lin;
      logic [63:0]        grav;
      logic [63:0]        pos;
      logic signed [63:0] h;
      pixel_t             px;
      if (req == REQ_RESTART) begin
        live_balls = balls_for(ball_count);
        for (int unsigned i = 0; i < live_balls; i++) begin
          bounce_ms[i] = now;
          speed[i]     = SPEED_START;
          damping[i]   = damping_of(i, live_balls);
        end
        return;
      end
      for (int unsigned i = 0; i < live_balls; i++) begin
        ms = now - bounce_ms[i];
        if (ms > ELAPSED_CAP) begin
          ms = ELAPSED_CAP;
        end
        tq   = ({32'd0, ms} * 64'd65536 + 64'd500) / 64'd1000;
        sq   = (tq * tq + 64'd32768) >> 16;
        lin  = ({44'd0, speed[i]} * tq + 64'd32768) >> 16;
        grav = (HALF_GRAVITY * sq + 64'd32768) >> 16;
        h    = $signed(lin) - $signed(grav);
        // Bounce: floor the height, damp the speed, restamp
        if (h < 0) begin
          h            = 0;
          speed[i]     = 20'(({44'd0, speed[i]} * {48'd0, damping[i]} + 64'd32768) >> 16);
          bounce_ms[i] = now;
          if (speed[i] < SPEED_FLOOR) begin
            speed[i] = SPEED_START;
          end
        end
        pos = ($unsigned(h) * 64'(STRIP_LEN - 1) + 64'd32768) >> 16;
        if (pos > 64'(STRIP_LEN - 1)) begin
          pos = 64'(STRIP_LEN - 1);
        end
        px.pos   = pos[PIX_W-1:0];
        px.red   = red;
        px.green = green;
        px.blue  = blue;
        px.last  = (i + 1 == live_balls);
        owed_pixels.push_back(px);
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (owed_pixels.size() == 0) begin
        $error("unexpected pixel: pixel_index %0d", got.pos);
        errors++;
        return;
      end
      want = owed_pixels.pop_front();
      if (got.pos !== want.pos) begin
        $error("pixel_index mismatch: expected %0d, actual %0d", want.pos, got.pos);
        errors++;
      end
      if (got.red !== want.red) begin
        $error("pixel_red mismatch: expected %0d, actual %0d", want.red, got.red);
        errors++;
      end
      if (got.green !== want.green) begin
        $error("pixel_green mismatch: expected %0d, actual %0d", want.green, got.green);
        errors++;
      end
      if (got.blue !== want.blue) begin
        $error("pixel_blue mismatch: expected %0d, actual %0d", want.blue, got.blue);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_of_frame mismatch: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return owed_pixels.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_req_type;
  logic [TIME_W-1:0]     in_now_ms;
  logic                  out_valid;
  logic                  out_stall;
  logic [PIX_W-1:0]      out_pixel_index;
  logic [COLOR_W-1:0]    out_pixel_red;
  logic [COLOR_W-1:0]    out_pixel_green;
  logic [COLOR_W-1:0]    out_pixel_blue;
  logic                  out_last_of_frame;

  pixel_scoreboard pixel_sb;
  logic [31:0]     clock_ms;
  int unsigned     items_sent;
  int unsigned     cycle_count;
  bit              tx_calm;
  logic            rx_calm;
  logic            hold_req;

  always #6 clk = ~clk;

  bouncing_ball_led_effect #(
    .MAX_BALLS    (NUM_BALLS),
    .STRIP_LENGTH (STRIP_LEN)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_index   (out_pixel_index),
    .out_pixel_red     (out_pixel_red),
    .out_pixel_green   (out_pixel_green),
    .out_pixel_blue    (out_pixel_blue),
    .out_last_of_frame (out_last_of_frame)
  );

  // Offer one transaction, hold it until accepted
  task automatic send_item(input logic req, input logic [31:0] now);
    while (!tx_calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_now_ms   <= now;
    do @(posedge clk); while (in_stall);
    pixel_sb.note_request(req, now);
    items_sent++;
  endtask

  // Drop valid, wait for all owed pixels, then let a restart finish
  task automatic drain();
    in_valid <= 1'b0;
    while (pixel_sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (RESTART_SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] count, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b);
    cfg_reg_t    regs[4];
    logic [7:0]  vals[4];
    regs = '{REG_BALL_COUNT, REG_COLOR_RED, REG_COLOR_GREEN, REG_COLOR_BLUE};
    vals = '{count, r, g, b};
    for (int k = 0; k < 4; k++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= regs[k];
      cfg_data  <= vals[k];
      @(posedge clk);
      pixel_sb.write_reg(regs[k], vals[k]);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Frame spacing: mostly short, some long enough to saturate or wrap
  function automatic logic [31:0] next_step();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5)  return 32'd0;
    if (r < 50) return $urandom_range(1, 60);
    if (r < 78) return $urandom_range(60, 600);
    if (r < 92) return $urandom_range(600, 3000);
    if (r < 98) return $urandom_range(3000, 70000);
    return $urandom();
  endfunction

  function automatic logic [7:0] pick_count();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd8;
      3: return 8'($urandom_range(9, 15));
      4: return 8'hF0 | 8'($urandom_range(0, 15));
      default: return 8'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [7:0] pick_level();
    if ($urandom_range(0, 4) == 0) begin
      return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // An optional restart, then a run of frames with an occasional restart mixed in
  task automatic run_phase(input int unsigned n_frames, input bit start_fresh);
    if (start_fresh) begin
      clock_ms += next_step();
      send_item(REQ_RESTART, clock_ms);
    end
    repeat (n_frames) begin
      clock_ms += next_step();
      if ($urandom_range(0, 14) == 0) begin
        send_item(REQ_RESTART, clock_ms);
      end else begin
        send_item(REQ_FRAME, clock_ms);
      end
    end
  endtask

  // Stimulus
  initial begin
    int unsigned random_start;
    int unsigned phase;
    pixel_sb    = new();
    tx_calm     = 1'b0;
    clock_ms    = 32'd0;
    items_sent  = 0;
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_index   <= REG_BALL_COUNT;
    cfg_data    <= 8'd0;
    in_valid    <= 1'b0;
    in_req_type <= REQ_RESTART;
    in_now_ms   <= 32'd0;
    rx_calm     <= 1'b0;
    hold_req    <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Frames from the reset state, near the peak, past saturation
    send_item(REQ_FRAME, 32'd0);
    send_item(REQ_FRAME, 32'd451);
    send_item(REQ_FRAME, 32'd452);
    send_item(REQ_FRAME, 32'd70000);
    send_item(REQ_RESTART, 32'd80000);
    send_item(REQ_FRAME, 32'd80000);
    send_item(REQ_FRAME, 32'd80451);
    send_item(REQ_FRAME, 32'd80452);
    send_item(REQ_FRAME, 32'd80903);
    send_item(REQ_FRAME, 32'd82000);

    // Ball count zero, color extremes
    drain();
    set_config(8'h00, 8'h00, 8'hFF, 8'h80);
    send_item(REQ_RESTART, 32'd100000);
    send_item(REQ_FRAME, 32'd100451);
    send_item(REQ_FRAME, 32'd101000);
    send_item(REQ_FRAME, 32'd103000);

    // Count far above the maximum, time wrapping through zero
    drain();
    set_config(8'h0F, 8'h55, 8'h00, 8'hFF);
    send_item(REQ_RESTART, 32'hFFFF_FF00);
    send_item(REQ_FRAME, 32'hFFFF_FFFF);
    send_item(REQ_FRAME, 32'h0000_0100);
    send_item(REQ_FRAME, 32'h0002_0000);

    // Count just above the maximum
    drain();
    set_config(8'h09, 8'hFF, 8'hFF, 8'hFF);
    send_item(REQ_RESTART, 32'h0003_0000);
    send_item(REQ_FRAME, 32'h0003_01C3);
    send_item(REQ_FRAME, 32'h0003_01C4);
    clock_ms = 32'h0003_1000;

    // Random phases with fresh settings each time
    random_start = items_sent;
    phase        = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      drain();
      tx_calm = (phase == 1);
      rx_calm <= (phase == 1);
      set_config(pick_count(), pick_level(), pick_level(), pick_level());
      if (phase == 3) begin
        hold_req <= 1'b1;
      end
      run_phase($urandom_range(18, 36), $urandom_range(0, 99) < 85);
      phase++;
    end
    drain();

    if (pixel_sb.errors == 0 && pixel_sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result channel: check accepted pixels, stall at random or on a long hold
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    pixel_t      got;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.pos   = out_pixel_index;
        got.red   = out_pixel_red;
        got.green = out_pixel_green;
        got.blue  = out_pixel_blue;
        got.last  = out_last_of_frame;
        pixel_sb.check_pixel(got);
      end
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (rx_calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 10);
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule
